// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the checker file
// both expect clk and arst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/zmssd_pkg.sv -----
package zmssd_pkg;

	localparam int PATCH_PIXELS_DEF = 64;

	localparam int SCORE_W = 22;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 22'h3F_FFFF;
	localparam logic [7:0] THRESH_RESET = 8'd10;

	localparam logic [1:0] ACT_REF    = 2'd0;
	localparam logic [1:0] ACT_CAND   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  pixel;
		logic [15:0] candidate_index;
		logic [11:0] candidate_x;
		logic [11:0] candidate_y;
	} pix_item_t;

	typedef struct packed {
		logic               found;
		logic [15:0]        best_index;
		logic [11:0]        best_x;
		logic [11:0]        best_y;
		logic [SCORE_W-1:0] best_score;
	} res_item_t;

	typedef struct packed {
		logic ref_wr;
		logic cand_wr;
		logic cand_end;
		logic finish;
		logic cfg_wr;
		logic score_upd;
	} dp_cmd_t;

	typedef struct packed {
		logic cand_last;
	} dp_status_t;

endpackage

// ----- rtl/core/zmssd_ctrl.sv -----
module zmssd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	input  logic [1:0]             pix_action,
	output logic                   pix_stall,
	output logic                   res_valid,
	input  logic                   res_stall,
	input  logic                   cfg_we,
	input  zmssd_pkg::dp_status_t  status,
	output zmssd_pkg::dp_cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_QUO  = 3'd4;
	localparam logic [2:0] ST_FIX  = 3'd5;
	localparam logic [2:0] ST_CMP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       res_valid_q;
	logic       accept;
	logic       is_finish;

	assign is_finish = (pix_action == zmssd_pkg::ACT_FINISH);
	// a finish needs the result register free or being emptied
	assign pix_stall = (state_q != ST_IDLE) || (is_finish && res_valid_q && res_stall);
	assign accept    = pix_valid && !pix_stall;

	always_comb begin
		cmd.ref_wr    = accept && (pix_action == zmssd_pkg::ACT_REF);
		cmd.cand_wr   = accept && (pix_action == zmssd_pkg::ACT_CAND);
		cmd.cand_end  = accept && (pix_action == zmssd_pkg::ACT_CAND) && status.cand_last;
		cmd.finish    = accept && is_finish;
		cmd.cfg_wr    = cfg_we;
		cmd.score_upd = (state_q == ST_CMP);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.cand_end) state_nxt = ST_ACC;
			end
			ST_ACC:  state_nxt = ST_SQ;
			ST_SQ:   state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_QUO;
			ST_QUO:  state_nxt = ST_FIX;
			ST_FIX:  state_nxt = ST_CMP;
			ST_CMP:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ----- rtl/core/zmssd_dp.sv -----
module zmssd_dp #(
	parameter int PATCH_PIXELS = zmssd_pkg::PATCH_PIXELS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  zmssd_pkg::dp_cmd_t     cmd,
	output zmssd_pkg::dp_status_t  status,
	input  zmssd_pkg::pix_item_t   pix,
	input  logic [7:0]             cfg_wdata,
	output zmssd_pkg::res_item_t   res
);

	localparam int CW     = $clog2(PATCH_PIXELS);
	localparam int SUM_W  = $clog2(255 * PATCH_PIXELS + 1);
	localparam int SQS_W  = $clog2(65025 * PATCH_PIXELS + 1);
	localparam int SQ_W   = 2 * SUM_W;
	localparam int SC_W   = SQ_W + 3;
	localparam int PW     = $clog2(PATCH_PIXELS + 1);
	localparam int LIM_W  = ((16 + PW > zmssd_pkg::SCORE_W) ? 16 + PW : zmssd_pkg::SCORE_W) + 1;
	localparam int SW     = zmssd_pkg::SCORE_W;

	localparam logic [CW-1:0]   LAST_POS = CW'(PATCH_PIXELS - 1);
	localparam logic [SQ_W-1:0] NPIX     = SQ_W'(PATCH_PIXELS);
	// floor(2^SQ_W / N): quotient estimate is low by at most one
	localparam logic [SQ_W-1:0] RECIP    = SQ_W'((64'd1 << SQ_W) / 64'(PATCH_PIXELS));

	function automatic logic [SW-1:0] limit_of(input logic [7:0] t);
		logic [LIM_W-1:0] full;
		full = LIM_W'(t) * LIM_W'(t) * LIM_W'(PATCH_PIXELS);
		if (full > LIM_W'(zmssd_pkg::SCORE_MAX)) begin
			limit_of = zmssd_pkg::SCORE_MAX;
		end else begin
			limit_of = full[SW-1:0];
		end
	endfunction

	logic [7:0]       ref_mem [PATCH_PIXELS];
	logic [7:0]       thresh_q;
	logic [CW-1:0]    ref_cnt_q;
	logic [CW-1:0]    cand_cnt_q;
	logic [SUM_W-1:0] ref_sum_q;
	logic [SQS_W-1:0] ref_sq_q;
	logic [SUM_W-1:0] cand_sum_q;
	logic [SQS_W-1:0] cand_sq_q;
	logic [SQS_W-1:0] cross_q;

	logic [7:0]       px_s1;
	logic [7:0]       rd_s1;
	logic             acc_s1;
	logic             first_s1;

	logic [15:0]      tag_idx_q;
	logic [11:0]      tag_x_q;
	logic [11:0]      tag_y_q;

	logic [SQ_W-1:0]          sq_s2;
	logic signed [SC_W-1:0]   base_s2;
	logic [2*SQ_W-1:0]        prod_s3;
	logic [SQ_W-1:0]          sq_s3;
	logic [SQ_W-1:0]          q0_s4;
	logic [SQ_W-1:0]          sq_s4;
	logic [SQ_W-1:0]          q_s5;

	logic [SW-1:0]    best_q;
	logic [15:0]      best_idx_q;
	logic [11:0]      best_x_q;
	logic [11:0]      best_y_q;
	logic             found_q;
	zmssd_pkg::res_item_t res_q;

	logic [15:0]                ref_px_sq;
	logic [15:0]                cand_px_sq;
	logic [15:0]                cross_px;
	logic signed [SUM_W:0]      diff;
	logic signed [2*SUM_W+1:0]  diff_sq;
	logic signed [SC_W-1:0]     base_c;
	logic [SQ_W-1:0]            q0_times_n;
	logic [SQ_W-1:0]            rem;
	logic signed [SC_W-1:0]     score_full;
	logic [SW-1:0]              score_c;

	assign status.cand_last = (cand_cnt_q == LAST_POS);

	assign ref_px_sq  = 16'(pix.pixel) * 16'(pix.pixel);
	assign cand_px_sq = 16'(px_s1) * 16'(px_s1);
	assign cross_px   = 16'(px_s1) * 16'(rd_s1);

	// reference store, read into a register alongside the candidate pixel for the accumulate
	always_ff @(posedge clk) begin
		if (cmd.ref_wr) begin
			ref_mem[ref_cnt_q] <= pix.pixel;
		end
		rd_s1 <= ref_mem[cand_cnt_q];
		px_s1 <= pix.pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cnt_q <= '0;
			ref_sum_q <= '0;
			ref_sq_q  <= '0;
		end else if (cmd.ref_wr) begin
			if (ref_cnt_q == '0) begin
				ref_sum_q <= SUM_W'(pix.pixel);
				ref_sq_q  <= SQS_W'(ref_px_sq);
			end else begin
				ref_sum_q <= ref_sum_q + SUM_W'(pix.pixel);
				ref_sq_q  <= ref_sq_q + SQS_W'(ref_px_sq);
			end
			ref_cnt_q <= (ref_cnt_q == LAST_POS) ? '0 : ref_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_cnt_q <= '0;
			acc_s1     <= 1'b0;
			first_s1   <= 1'b0;
			cand_sum_q <= '0;
			cand_sq_q  <= '0;
			cross_q    <= '0;
		end else begin
			acc_s1   <= cmd.cand_wr;
			first_s1 <= cmd.cand_wr && (cand_cnt_q == '0);
			if (cmd.finish) begin
				cand_cnt_q <= '0;
			end else if (cmd.cand_wr) begin
				cand_cnt_q <= (cand_cnt_q == LAST_POS) ? '0 : cand_cnt_q + 1'b1;
			end
			// finish drops a partly streamed candidate, including its last pending pixel
			if (cmd.finish) begin
				cand_sum_q <= '0;
				cand_sq_q  <= '0;
				cross_q    <= '0;
			end else if (acc_s1) begin
				if (first_s1) begin
					cand_sum_q <= SUM_W'(px_s1);
					cand_sq_q  <= SQS_W'(cand_px_sq);
					cross_q    <= SQS_W'(cross_px);
				end else begin
					cand_sum_q <= cand_sum_q + SUM_W'(px_s1);
					cand_sq_q  <= cand_sq_q + SQS_W'(cand_px_sq);
					cross_q    <= cross_q + SQS_W'(cross_px);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cand_end) begin
			tag_idx_q <= pix.candidate_index;
			tag_x_q   <= pix.candidate_x;
			tag_y_q   <= pix.candidate_y;
		end
	end

	// score pipeline; sums stay still while the controller walks it
	assign diff    = $signed({1'b0, ref_sum_q}) - $signed({1'b0, cand_sum_q});
	assign diff_sq = diff * diff;
	assign base_c  = $signed(SC_W'(ref_sq_q)) + $signed(SC_W'(cand_sq_q))
		- $signed(SC_W'({cross_q, 1'b0}));

	assign q0_times_n = q0_s4 * NPIX;
	assign rem        = sq_s4 - q0_times_n;

	always_ff @(posedge clk) begin
		sq_s2   <= diff_sq[SQ_W-1:0];
		base_s2 <= base_c;
		prod_s3 <= (2*SQ_W)'(sq_s2) * (2*SQ_W)'(RECIP);
		sq_s3   <= sq_s2;
		q0_s4   <= prod_s3[2*SQ_W-1:SQ_W];
		sq_s4   <= sq_s3;
		q_s5    <= (rem >= NPIX) ? q0_s4 + 1'b1 : q0_s4;
	end

	assign score_full = base_s2 - $signed({3'b000, q_s5});

	always_comb begin
		if (score_full < 0) begin
			score_c = '0;
		end else if (score_full > $signed(SC_W'(zmssd_pkg::SCORE_MAX))) begin
			score_c = zmssd_pkg::SCORE_MAX;
		end else begin
			score_c = score_full[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= zmssd_pkg::THRESH_RESET;
			best_q     <= limit_of(zmssd_pkg::THRESH_RESET);
			best_idx_q <= '0;
			best_x_q   <= '0;
			best_y_q   <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				thresh_q <= cfg_wdata;
			end
			if (cmd.finish) begin
				best_q     <= limit_of(thresh_q);
				best_idx_q <= '0;
				best_x_q   <= '0;
				best_y_q   <= '0;
				found_q    <= 1'b0;
			end else if (cmd.cfg_wr && !found_q) begin
				best_q <= limit_of(cfg_wdata);
			end else if (cmd.score_upd && (score_c < best_q)) begin
				best_q     <= score_c;
				best_idx_q <= tag_idx_q;
				best_x_q   <= tag_x_q;
				best_y_q   <= tag_y_q;
				found_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.found      <= found_q;
			res_q.best_index <= best_idx_q;
			res_q.best_x     <= best_x_q;
			res_q.best_y     <= best_y_q;
			res_q.best_score <= best_q;
		end
	end

	assign res = res_q;

endmodule

// ----- rtl/core/zero_mean_ssd_best_match.sv -----
// Zero-mean SSD best match over patches of PATCH_PIXELS 8-bit pixels. Reference
// and candidate pixels are taken one per cycle while the input is not stalled;
// the last pixel of a candidate stalls the input while its score goes
// through squaring, the reciprocal division by the patch size, the remainder
// fix-up and the compare against the best so far. A finish item loads the
// result register; it waits while a score is in progress or an earlier
// result is still held there and stalled. The reference patch sits in a small
// RAM with no reset and no clearing pass; read only entries already loaded.
module zero_mean_ssd_best_match #(
	parameter int PATCH_PIXELS = zmssd_pkg::PATCH_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  zmssd_pkg::pix_item_t  pix,
	output logic                  res_valid,
	input  logic                  res_stall,
	output zmssd_pkg::res_item_t  res,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata
);

	zmssd_pkg::dp_cmd_t    cmd;
	zmssd_pkg::dp_status_t status;

	zmssd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_action (pix.action),
		.pix_stall  (pix_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cfg_we     (cfg_we),
		.status     (status),
		.cmd        (cmd)
	);

	zmssd_dp #(
		.PATCH_PIXELS (PATCH_PIXELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pix       (pix),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

endmodule

// ----- rtl/core/zmssd_checker.sv -----
`include "assert_macros.svh"

module zmssd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pix_valid,
	input logic                  pix_stall,
	input zmssd_pkg::pix_item_t  pix,
	input logic                  res_valid,
	input logic                  res_stall,
	input zmssd_pkg::res_item_t  res
);

	// a waiting result holds until taken
	`ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result item changed while stalled")

	// a result only shows up right after a finish item went in
	`ASSERT_CLK(a_res_cause, $rose(res_valid) |-> $past(pix_valid && !pix_stall && (pix.action == zmssd_pkg::ACT_FINISH)), "result item without finish")

	// nothing found means an empty tag
	`ASSERT_NEVER(a_empty_tag, res_valid && !res.found && (res.best_index != 16'd0 || res.best_x != 12'd0 || res.best_y != 12'd0), "tag set on a not-found result")

endmodule

bind zero_mean_ssd_best_match zmssd_checker u_zmssd_checker (.*);
